[hdl/rtvc_pkg.sv]
// Shared types, character codes and helpers for the release tag version compare block.
`default_nettype none
package rtvc_pkg;

  localparam int PART_W    = 20;
  localparam int CHAR_W    = 16;
  localparam int REG_COUNT = 4;
  localparam int REG_IDX_W = 2;
  localparam int CFG_IDX_W = 8;
  localparam int OUT_W     = 8;

  localparam logic [PART_W-1:0] PART_CEIL = 20'd99999;

  // input kinds (tuser)
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAJOR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINOR = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATCH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUILD = 8'd3;

  localparam logic [CHAR_W-1:0] CHAR_SLASH = 16'h002F;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 16'h002E;
  localparam logic [CHAR_W-1:0] CHAR_0     = 16'h0030;
  localparam logic [CHAR_W-1:0] CHAR_9     = 16'h0039;
  localparam logic [CHAR_W-1:0] CHAR_V_UP  = 16'h0056;
  localparam logic [CHAR_W-1:0] CHAR_V_LO  = 16'h0076;

  // control from the input stage to the tag tracker
  typedef struct packed {
    logic step;   // one character item is consumed
    logic clear;  // end item: tag state returns to reset
  } trk_ctl_t;

  // one decimal digit into a component; a value already at or above PART_CEIL becomes PART_CEIL
  function automatic logic [PART_W-1:0] next_part(input logic [PART_W-1:0] v,
                                                  input logic [3:0] digit);
    logic [PART_W-1:0] times10;
    times10 = (v << 3) + (v << 1);
    if (v >= PART_CEIL) begin
      next_part = PART_CEIL;
    end else begin
      next_part = times10 + {{(PART_W-4){1'b0}}, digit};
    end
  endfunction

endpackage
`default_nettype wire

[hdl/rtvc_tag_track.sv]
// Tag tracker: per-character update of components, length, start and bad flags.
`default_nettype none
module rtvc_tag_track #(
  parameter int TAG_CAPACITY = 32,
  parameter int PART_COUNT   = 4
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  rtvc_pkg::trk_ctl_t           ctl_i,
  input  wire [rtvc_pkg::CHAR_W-1:0]   char_i,
  output logic [rtvc_pkg::PART_W-1:0]  parts_o [PART_COUNT],
  output logic                         accepted_o
);
  import rtvc_pkg::*;

  localparam int LEN_W = $clog2(TAG_CAPACITY + 1);
  localparam int IDX_W = $clog2(PART_COUNT + 1);

  logic [PART_W-1:0] parts_r   [PART_COUNT];
  logic [PART_W-1:0] parts_nxt [PART_COUNT];
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              start_r, start_nxt;
  logic              bad_r, bad_nxt;

  logic is_digit, is_vee, is_dot, is_slash;

  assign is_digit = char_i inside {[CHAR_0:CHAR_9]};
  assign is_vee   = char_i inside {CHAR_V_LO, CHAR_V_UP};
  assign is_dot   = (char_i == CHAR_DOT);
  assign is_slash = (char_i == CHAR_SLASH);

  always_comb begin
    parts_nxt = parts_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    start_nxt = start_r;
    bad_nxt   = bad_r;
    if (ctl_i.clear || (ctl_i.step && is_slash)) begin
      for (int k = 0; k < PART_COUNT; k++) begin
        parts_nxt[k] = '0;
      end
      idx_nxt   = '0;
      len_nxt   = '0;
      start_nxt = 1'b1;
      bad_nxt   = 1'b0;
    end else if (ctl_i.step) begin
      start_nxt = 1'b0;
      // leading v/V of a tag is dropped
      if (!(start_r && is_vee)) begin
        if (len_r < LEN_W'(TAG_CAPACITY)) begin
          len_nxt = len_r + LEN_W'(1);
        end
        if (is_digit) begin
          for (int k = 0; k < PART_COUNT; k++) begin
            if (idx_r == IDX_W'(k)) begin
              parts_nxt[k] = next_part(parts_r[k], char_i[3:0]);
            end
          end
        end else if (is_dot) begin
          if (idx_r < IDX_W'(PART_COUNT)) begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end else begin
          bad_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PART_COUNT; k++) begin
        parts_r[k] <= '0;
      end
      idx_r   <= '0;
      len_r   <= '0;
      start_r <= 1'b1;
      bad_r   <= 1'b0;
    end else begin
      parts_r <= parts_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      start_r <= start_nxt;
      bad_r   <= bad_nxt;
    end
  end

  assign parts_o    = parts_r;
  assign accepted_o = !bad_r && (len_r != '0) && (len_r < LEN_W'(TAG_CAPACITY));

endmodule
`default_nettype wire

[hdl/rtvc_ver_cmp.sv]
// Version compare: first differing component decides, missing current parts are zero.
`default_nettype none
module rtvc_ver_cmp #(
  parameter int PART_COUNT = 4
) (
  input  wire [rtvc_pkg::PART_W-1:0] parts_i [PART_COUNT],
  input  wire [rtvc_pkg::PART_W-1:0] cur_i   [rtvc_pkg::REG_COUNT],
  input  wire                        accepted_i,
  output logic                       newer_o
);
  import rtvc_pkg::*;

  logic [PART_W-1:0] cur_ext [PART_COUNT];
  logic              decided;
  logic              gt;

  for (genvar k = 0; k < PART_COUNT; k++) begin : g_cur
    if (k < REG_COUNT) begin : g_reg
      assign cur_ext[k] = cur_i[k];
    end else begin : g_zero
      assign cur_ext[k] = '0;
    end
  end

  always_comb begin
    decided = 1'b0;
    gt      = 1'b0;
    for (int k = 0; k < PART_COUNT; k++) begin
      if (!decided && (parts_i[k] != cur_ext[k])) begin
        decided = 1'b1;
        gt      = parts_i[k] > cur_ext[k];
      end
    end
    newer_o = accepted_i && gt;
  end

endmodule
`default_nettype wire

[hdl/release_tag_version_compare_unit.sv]
// Top level: input register, tag tracker, version compare and result register.
// An end item goes through the input register and then the result register onto out_*.
// Character items produce no result; through the input register they update the tag state.
// Throughput: one item per cycle; in_tready drops only while an end item waits
// on a full, stalled result register.
// Reset (rst_n low, synchronous): both stages empty, tag state cleared, registers zero.
`default_nettype none
module release_tag_version_compare_unit #(
  parameter int TAG_CAPACITY = 32,
  parameter int PART_COUNT   = 4
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // character stream
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire [rtvc_pkg::CHAR_W-1:0]      in_tdata,   // [15:0] char_code
  input  wire                             in_tuser,   // [0] kind (1 = end of string)
  // result stream
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [rtvc_pkg::OUT_W-1:0]      out_tdata,  // [0] tag_accepted, [1] is_newer, rest 0
  // register writes
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [rtvc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [rtvc_pkg::PART_W-1:0]      cfg_data
);
  import rtvc_pkg::*;

  // current version registers
  logic [PART_W-1:0] cur_r [REG_COUNT];

  // input register stage
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_kind_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_adv;
  logic              in_acc;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic              out_acc_r;
  logic              out_newer_r;
  logic              out_load;

  trk_ctl_t          trk_ctl;
  logic [PART_W-1:0] parts [PART_COUNT];
  logic              accepted;
  logic              newer;

  assign cfg_ready = 1'b1;

  // register index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < REG_COUNT; k++) begin
        cur_r[k] <= '0;
      end
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
      cur_r[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  // a character always moves on; an end item needs room in the result register
  assign s1_adv    = s1_valid_r && ((s1_kind_r == KIND_CHAR) || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= in_tuser;
      s1_char_r <= in_tdata;
    end
  end

  assign trk_ctl.step  = s1_adv && (s1_kind_r == KIND_CHAR);
  assign trk_ctl.clear = s1_adv && (s1_kind_r == KIND_END);

  rtvc_tag_track #(
    .TAG_CAPACITY (TAG_CAPACITY),
    .PART_COUNT   (PART_COUNT)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (trk_ctl),
    .char_i     (s1_char_r),
    .parts_o    (parts),
    .accepted_o (accepted)
  );

  rtvc_ver_cmp #(
    .PART_COUNT (PART_COUNT)
  ) u_cmp (
    .parts_i    (parts),
    .cur_i      (cur_r),
    .accepted_i (accepted),
    .newer_o    (newer)
  );

  // the end item sees the tag state left by the preceding characters
  assign out_load = trk_ctl.clear;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_acc_r   <= accepted;
      out_newer_r <= newer;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-2){1'b0}}, out_newer_r, out_acc_r};

endmodule
`default_nettype wire

[hdl/rtvc_checker.sv]
// Port-level checker for the release tag version compare unit, with its bind.
`default_nettype none
module rtvc_checker (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           out_tvalid,
  input wire                           out_tready,
  input wire [rtvc_pkg::OUT_W-1:0]     out_tdata
);
  import rtvc_pkg::*;

  // a result waiting on a stall keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // newer only for an accepted tag
  a_newer_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[1] && !out_tdata[0]))
    else $error("is_newer set on a rejected tag");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_W-1:2] == '0))
    else $error("result padding not zero");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind release_tag_version_compare_unit rtvc_checker u_rtvc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
